// File: hw/rtl/taee_pkg.sv
package taee_pkg;

    localparam int DataW = 32;
    localparam int SlotW = 5;

    localparam logic       ActLoad = 1'b0;
    localparam logic       ActExec = 1'b1;
    localparam logic [1:0] OpMul   = 2'd0;
    localparam logic [1:0] OpAdd   = 2'd1;
    localparam logic [1:0] OpSub   = 2'd2;
    localparam logic [1:0] OpDiv   = 2'd3;

    // classified word passed from front to back
    typedef struct packed {
        logic             act;
        logic [SlotW-1:0] load_index;
        logic [DataW-1:0] load_value;
        logic [SlotW-1:0] src_a;
        logic [SlotW-1:0] src_b;
        logic [1:0]       opcode;
        logic [SlotW-1:0] dest;
        logic             is_final;
    } t_cmd;

    localparam int CmdW = $bits(t_cmd);

endpackage

// File: hw/rtl/taee_ram.sv
module taee_ram #(
    parameter int Width = 32,
    parameter int Depth = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: hw/rtl/taee_front.sv
module taee_front import taee_pkg::*; #(
    parameter int Depth = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_cmd        i_cmd,
    output logic        o_valid,
    input  logic        i_ready,
    output t_cmd        o_cmd
);
    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

    t_cmd             r_q [Depth];
    logic [PtrW-1:0]  r_wp, r_rp;
    logic [PtrW:0]    r_cnt;
    logic             push, pop;

    assign o_ready = (r_cnt != (PtrW+1)'(Depth));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_q[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PtrW'(Depth-1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == PtrW'(Depth-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PtrW+1)'(push) - (PtrW+1)'(pop);
        end
        if (push) begin
            r_q[r_wp] <= i_cmd;
        end
    end
endmodule

// File: hw/rtl/taee_div.sv
module taee_div import taee_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DataW-1:0] i_a,
    input  logic [DataW-1:0] i_b,
    output logic             o_done,
    output logic [DataW-1:0] o_q
);
    logic [DataW-1:0] r_rem, r_quo, r_den;
    logic [5:0]       r_cnt;
    logic             r_busy, r_neg, r_zero;
    logic [DataW:0]   trial;
    logic [DataW-1:0] shifted;

    assign shifted = {r_rem[DataW-2:0], r_quo[DataW-1]};
    assign trial   = {1'b0, shifted} - {1'b0, r_den};
    assign o_q     = r_zero ? '0 : (r_neg ? (~r_quo + 1'b1) : r_quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 6'(DataW-1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_rem  <= '0;
            r_quo  <= i_a[DataW-1] ? (~i_a + 1'b1) : i_a;
            r_den  <= i_b[DataW-1] ? (~i_b + 1'b1) : i_b;
            r_neg  <= i_a[DataW-1] ^ i_b[DataW-1];
            r_zero <= (i_b == '0);
        end else if (r_busy) begin
            // restoring step, one quotient bit
            r_quo <= {r_quo[DataW-2:0], ~trial[DataW]};
            r_rem <= trial[DataW] ? shifted : trial[DataW-1:0];
        end
    end
endmodule

// File: hw/rtl/taee_back.sv
module taee_back import taee_pkg::*; #(
    parameter int NumVars = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_cmd             i_cmd,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [DataW-1:0] o_value,
    output logic             o_dbz
);
    localparam int AW = (NumVars > 1) ? $clog2(NumVars) : 1;

    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StRdA  = 3'd1;
    localparam logic [2:0] StRdB  = 3'd2;
    localparam logic [2:0] StExe  = 3'd3;
    localparam logic [2:0] StDiv  = 3'd4;
    localparam logic [2:0] StFin  = 3'd5;
    localparam logic [2:0] StCalc = 3'd6;

    logic [2:0]       r_st;
    t_cmd             r_cmd;
    logic [DataW-1:0] r_a, r_b, r_res;
    logic             r_dbz, r_ov;
    logic             we;
    logic [AW-1:0]    waddr, raddr;
    logic [DataW-1:0] wdata, rdata, q, mul, alu;
    logic             div_start, div_done;
    logic             a_in, b_in, d_in;

    function automatic logic in_range(input logic [SlotW-1:0] s);
        return (32'(s) < 32'(NumVars));
    endfunction

    assign a_in = in_range(r_cmd.src_a);
    assign b_in = in_range(r_cmd.src_b);
    assign d_in = in_range(r_cmd.dest);

    taee_ram #(.Width(DataW), .Depth(NumVars)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    taee_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_a(r_a), .i_b(r_b), .o_done(div_done), .o_q(q)
    );

    assign o_ready = (r_st == StIdle);
    assign o_valid = r_ov;
    assign mul     = r_a * r_b;
    assign div_start = (r_st == StCalc) && (r_cmd.opcode == OpDiv);

    always_comb begin
        case (r_cmd.opcode)
            OpMul:   alu = mul;
            OpAdd:   alu = r_a + r_b;
            OpSub:   alu = r_a - r_b;
            default: alu = q;
        endcase
    end

    always_comb begin
        we    = 1'b0;
        waddr = AW'(r_cmd.dest);
        wdata = r_res;
        raddr = AW'(r_cmd.src_a);
        if (r_st == StIdle && i_valid && i_cmd.act == ActLoad) begin
            we    = in_range(i_cmd.load_index);
            waddr = AW'(i_cmd.load_index);
            wdata = i_cmd.load_value;
        end else if (r_st == StFin) begin
            we = !r_cmd.is_final && d_in;
        end
        if (r_st == StRdB) begin
            raddr = AW'(r_cmd.src_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= StIdle;
            r_dbz <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
            case (r_st)
                StIdle: begin
                    if (i_valid && i_cmd.act == ActExec) begin
                        r_st <= StRdA;
                    end
                end
                StRdA: r_st <= StRdB;
                StRdB: r_st <= StExe;
                StExe: r_st <= StCalc;
                StCalc: r_st <= (r_cmd.opcode == OpDiv) ? StDiv : StFin;
                StDiv: begin
                    if (div_done) begin
                        r_st <= StFin;
                        if (r_b == '0) begin
                            r_dbz <= 1'b1;
                        end
                    end
                end
                StFin: begin
                    if (!r_cmd.is_final) begin
                        r_st <= StIdle;
                    end else if (!r_ov) begin
                        r_ov  <= 1'b1;
                        r_dbz <= 1'b0;
                        r_st  <= StIdle;
                    end
                end
                default: r_st <= StIdle;
            endcase
        end
        if (r_st == StIdle && i_valid) begin
            r_cmd <= i_cmd;
        end
        // store read data arrives in the cycle after the address
        if (r_st == StRdB) begin
            r_a <= a_in ? rdata : '0;
        end
        if (r_st == StExe) begin
            r_b <= b_in ? rdata : '0;
        end
        if (r_st == StCalc && r_cmd.opcode != OpDiv) begin
            r_res <= alu;
        end
        if ((r_st == StDiv && div_done)) begin
            r_res <= q;
        end
        if (r_st == StFin && r_cmd.is_final && !r_ov) begin
            o_value <= r_res;
            o_dbz   <= r_dbz;
        end
    end
endmodule

// File: hw/rtl/three_address_equation_evaluator.sv
// Load word: queued, then stored; loads stream one per cycle while the back end is idle.
// Execute word: read A, read B, execute, calculate and finish for multiply/add/subtract;
// divide adds the 32-step restoring divider before finish; both read the store twice.
// The back end runs one execute word at a time and takes no new word until back in idle.
// Final-step result sits in an output register until m_axis_tready; a second final
// step stalls meanwhile. Sync active-low reset clears queue, control, divide flag.
module three_address_equation_evaluator import taee_pkg::*; #(
    parameter int NUM_VARS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: load_index, load_value, src_a, src_b, opcode, dest, zero pad
    input  logic [55:0] s_axis_tdata,
    // tuser: action
    input  logic        s_axis_tuser,
    // tlast: is_final
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: value, div_by_zero
    output logic [39:0] m_axis_tdata
);
    t_cmd             in_cmd, q_cmd;
    logic             q_valid, q_ready;
    logic [DataW-1:0] value;
    logic             dbz;

    assign in_cmd.act        = s_axis_tuser;
    assign in_cmd.load_index = s_axis_tdata[4:0];
    assign in_cmd.load_value = s_axis_tdata[36:5];
    assign in_cmd.src_a      = s_axis_tdata[41:37];
    assign in_cmd.src_b      = s_axis_tdata[46:42];
    assign in_cmd.opcode     = s_axis_tdata[48:47];
    assign in_cmd.dest       = s_axis_tdata[53:49];
    assign in_cmd.is_final   = s_axis_tlast;

    taee_front #(.Depth(2)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_cmd(in_cmd),
        .o_valid(q_valid), .i_ready(q_ready), .o_cmd(q_cmd)
    );

    taee_back #(.NumVars(NUM_VARS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_cmd(q_cmd),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_value(value), .o_dbz(dbz)
    );

    assign m_axis_tdata = {7'd0, dbz, value};
endmodule
